FILE: rtl/drtt_pkg.sv
package drtt_pkg;

  localparam int SLOTS = 5;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [9:0]  MAX_LEN       = 10'd512;
  localparam logic [9:0]  SPOOF_MIN     = 10'd12;
  localparam logic [9:0]  SPOOF_MAX     = 10'(512 - 16);
  localparam logic [9:0]  MIN_LEN       = 10'd2;

  localparam logic [1:0] MODE_QUERY = 2'd0;
  localparam logic [1:0] MODE_REPLY = 2'd1;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_SPOOF     = 3'd1,
    ACT_FORWARD   = 3'd2,
    ACT_FULL      = 3'd3,
    ACT_DELIVERED = 3'd4,
    ACT_NO_MATCH  = 3'd5,
    ACT_BAD_LEN   = 3'd6
  } action_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [15:0] limit;
  } cmp_req_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_rsp_t;

endpackage

FILE: rtl/drtt_age_cmp.sv
module drtt_age_cmp
  import drtt_pkg::*;
(
  input  cmp_req_t req,
  output cmp_rsp_t rsp
);

  logic [31:0] diff;

  assign diff   = req.a - req.b;
  assign rsp.eq = (diff == 32'd0);
  assign rsp.gt = (diff > {16'd0, req.limit});

endmodule

FILE: rtl/dns_relay_transaction_table_core.sv
// An accepted event runs an expiry scan over every slot, then raises the result strobe;
//   a reply of valid length first scans the slots for its id, stopping at the first hit.
// A new event is accepted only while idle; busy drops in the strobe cycle, and the
//   slot scans of the single shared subtract/compare unit set the pace.
// Reset (synchronous, rst_n low) frees all slots and loads timeout_ms with 3000.
// The receiver cannot stall: out_valid is a one-cycle strobe.
module dns_relay_transaction_table_core
  import drtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_now_ms,
  input  logic [9:0]  in_packet_length,
  input  logic [15:0] in_transaction_id,
  input  logic [31:0] in_source_ip,
  input  logic [15:0] in_source_port,
  input  logic        in_is_authenticated,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic [2:0]  out_slot_index,
  output logic [31:0] out_dest_ip,
  output logic [15:0] out_dest_port,
  output logic [2:0]  out_expired_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_MATCH  = 3'b010,
    ST_EXPIRE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  action_t           act_r, act_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [31:0]       dip_r, dip_nxt;
  logic [15:0]       dport_r, dport_nxt;
  logic [31:0]       now_r;
  logic [15:0]       txid_r;
  logic [15:0]       timeout_r;
  logic              out_valid_r, out_valid_nxt;
  logic [SLOTS-1:0]  valid_r, valid_nxt;

  logic [15:0]       txid_mem_r [SLOTS];
  logic [31:0]       ip_mem_r   [SLOTS];
  logic [15:0]       port_mem_r [SLOTS];
  logic [31:0]       time_mem_r [SLOTS];

  logic              accept;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic              write_slot;
  logic              last_idx;
  logic [9:0]        len_c;
  cmp_req_t          cmp_req;
  cmp_rsp_t          cmp_rsp;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign last_idx  = (idx_r == IDX_W'(SLOTS - 1));
  assign len_c     = (in_packet_length > MAX_LEN) ? MAX_LEN : in_packet_length;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    cmp_req.limit = timeout_r;
    if (state_r == ST_MATCH) begin
      cmp_req.a = {16'd0, txid_mem_r[idx_r]};
      cmp_req.b = {16'd0, txid_r};
    end else begin
      cmp_req.a = now_r;
      cmp_req.b = time_mem_r[idx_r];
    end
  end

  drtt_age_cmp u_cmp (
    .req (cmp_req),
    .rsp (cmp_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    slot_nxt      = slot_r;
    dip_nxt       = dip_r;
    dport_nxt     = dport_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    write_slot    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt   = '0;
          cnt_nxt   = '0;
          slot_nxt  = '0;
          dip_nxt   = '0;
          dport_nxt = '0;
          act_nxt   = ACT_NONE;
          state_nxt = ST_EXPIRE;
          if (in_mode == MODE_QUERY) begin
            if (!in_is_authenticated) begin
              act_nxt = (len_c >= SPOOF_MIN && len_c <= SPOOF_MAX) ? ACT_SPOOF : ACT_BAD_LEN;
            end else if (len_c < MIN_LEN) begin
              act_nxt = ACT_BAD_LEN;
            end else if (free_found) begin
              act_nxt             = ACT_FORWARD;
              slot_nxt            = free_idx;
              valid_nxt[free_idx] = 1'b1;
              write_slot          = 1'b1;
            end else begin
              act_nxt = ACT_FULL;
            end
          end else if (in_mode == MODE_REPLY) begin
            if (len_c < MIN_LEN) begin
              act_nxt = ACT_BAD_LEN;
            end else begin
              act_nxt   = ACT_NO_MATCH;
              state_nxt = ST_MATCH;
            end
          end
        end
      end
      ST_MATCH: begin
        if (valid_r[idx_r] && cmp_rsp.eq) begin
          act_nxt          = ACT_DELIVERED;
          slot_nxt         = idx_r;
          dip_nxt          = ip_mem_r[idx_r];
          dport_nxt        = port_mem_r[idx_r];
          valid_nxt[idx_r] = 1'b0;
          idx_nxt          = '0;
          state_nxt        = ST_EXPIRE;
        end else if (last_idx) begin
          idx_nxt   = '0;
          state_nxt = ST_EXPIRE;
        end else begin
          idx_nxt = IDX_W'(idx_r + 1'b1);
        end
      end
      ST_EXPIRE: begin
        if (valid_r[idx_r] && cmp_rsp.gt) begin
          valid_nxt[idx_r] = 1'b0;
          cnt_nxt          = CNT_W'(cnt_r + 1'b1);
        end
        if (last_idx) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt = IDX_W'(idx_r + 1'b1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    act_r   <= act_nxt;
    slot_r  <= slot_nxt;
    dip_r   <= dip_nxt;
    dport_r <= dport_nxt;
    if (accept) begin
      now_r  <= in_now_ms;
      txid_r <= in_transaction_id;
    end
    if (write_slot) begin
      txid_mem_r[free_idx] <= in_transaction_id;
      ip_mem_r[free_idx]   <= in_source_ip;
      port_mem_r[free_idx] <= in_source_port;
      time_mem_r[free_idx] <= in_now_ms;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = act_r;
  assign out_slot_index    = 3'(slot_r);
  assign out_dest_ip       = dip_r;
  assign out_dest_port     = dport_r;
  assign out_expired_count = 3'(cnt_r);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_dest_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action != ACT_DELIVERED)
      |-> (out_dest_ip == 32'd0 && out_dest_port == 16'd0))
    else $error("destination set without delivery");

  a_expired_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r <= CNT_W'(SLOTS)))
    else $error("expired count exceeds table size");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import drtt_pkg::*;

  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PHASE_EVENTS = 225;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] now;
    logic [9:0]  len;
    logic [15:0] txid;
    logic [31:0] ip;
    logic [15:0] port;
    logic        auth;
  } dns_event_t;

  typedef struct {
    action_t     action;
    logic [2:0]  slot;
    logic [31:0] dip;
    logic [15:0] dport;
    logic [2:0]  expired;
  } relay_verdict_t;

  typedef struct {
    dns_event_t     ev;
    bit             fixed;
    relay_verdict_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = '0;
  logic [31:0] in_now_ms = '0;
  logic [9:0]  in_packet_length = '0;
  logic [15:0] in_transaction_id = '0;
  logic [31:0] in_source_ip = '0;
  logic [15:0] in_source_port = '0;
  logic        in_is_authenticated = 1'b0;
  logic        out_valid;
  logic [2:0]  out_action;
  logic [2:0]  out_slot_index;
  logic [31:0] out_dest_ip;
  logic [15:0] out_dest_port;
  logic [2:0]  out_expired_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  logic        pend_valid [SLOTS];
  logic [15:0] pend_txid  [SLOTS];
  logic [31:0] pend_ip    [SLOTS];
  logic [15:0] pend_port  [SLOTS];
  logic [31:0] pend_stamp [SLOTS];
  logic [15:0] timeout_now = TIMEOUT_RESET;
  logic [31:0] clock_ms = '0;

  relay_verdict_t verdict_q [$];
  script_row_t    script_q [$];
  int             fail_count = 0;
  int             idle_pct [4] = '{0, 60, 0, 34};

  always #2 clk = ~clk;

  dns_relay_transaction_table_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_now_ms           (in_now_ms),
    .in_packet_length    (in_packet_length),
    .in_transaction_id   (in_transaction_id),
    .in_source_ip        (in_source_ip),
    .in_source_port      (in_source_port),
    .in_is_authenticated (in_is_authenticated),
    .out_valid           (out_valid),
    .out_action          (out_action),
    .out_slot_index      (out_slot_index),
    .out_dest_ip         (out_dest_ip),
    .out_dest_port       (out_dest_port),
    .out_expired_count   (out_expired_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  function automatic relay_verdict_t relay_decide(input dns_event_t ev);
    relay_verdict_t v;
    logic [9:0]     len;
    logic [31:0]    age;
    bit             done;
    v.action  = ACT_NONE;
    v.slot    = '0;
    v.dip     = '0;
    v.dport   = '0;
    v.expired = '0;
    len = (ev.len > MAX_LEN) ? MAX_LEN : ev.len;
    done = 1'b0;
    if (ev.mode == MODE_QUERY) begin
      if (!ev.auth) begin
        if (len >= SPOOF_MIN && len <= SPOOF_MAX) v.action = ACT_SPOOF;
        else v.action = ACT_BAD_LEN;
      end else if (len < MIN_LEN) begin
        v.action = ACT_BAD_LEN;
      end else begin
        v.action = ACT_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && !pend_valid[i]) begin
            pend_valid[i] = 1'b1;
            pend_txid[i]  = ev.txid;
            pend_ip[i]    = ev.ip;
            pend_port[i]  = ev.port;
            pend_stamp[i] = ev.now;
            v.action = ACT_FORWARD;
            v.slot   = 3'(i);
            done = 1'b1;
          end
        end
      end
    end else if (ev.mode == MODE_REPLY) begin
      if (len < MIN_LEN) begin
        v.action = ACT_BAD_LEN;
      end else begin
        v.action = ACT_NO_MATCH;
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && pend_valid[i] && pend_txid[i] == ev.txid) begin
            v.action = ACT_DELIVERED;
            v.slot   = 3'(i);
            v.dip    = pend_ip[i];
            v.dport  = pend_port[i];
            pend_valid[i] = 1'b0;
            done = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      age = ev.now - pend_stamp[i];
      if (pend_valid[i] && age > {16'd0, timeout_now}) begin
        pend_valid[i] = 1'b0;
        v.expired = v.expired + 3'd1;
      end
    end
    return v;
  endfunction

  function automatic dns_event_t make_event();
    dns_event_t ev;
    int         pick;
    int         live [$];
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) clock_ms = $urandom();
    else if ($urandom_range(0, 9) == 0) clock_ms += $urandom_range(0, 2 * timeout_now + 8);
    else clock_ms += $urandom_range(0, timeout_now / 4 + 2);
    ev.now  = clock_ms;
    ev.len  = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(12, 512));
    ev.txid = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom());
    ev.ip   = $urandom();
    ev.port = 16'($urandom());
    ev.auth = 1'b1;
    if (pick < 45) begin
      ev.mode = MODE_QUERY;
    end else if (pick < 80) begin
      ev.mode = MODE_REPLY;
      for (int i = 0; i < SLOTS; i++) begin
        if (pend_valid[i]) live.push_back(i);
      end
      if (live.size() > 0 && $urandom_range(0, 3) != 0)
        ev.txid = pend_txid[live[$urandom_range(0, live.size() - 1)]];
    end else if (pick < 90) begin
      ev.mode = MODE_QUERY;
      ev.auth = 1'b0;
    end else begin
      ev.mode = (pick < 96) ? MODE_TICK : MODE_UNUSED;
      ev.auth = 1'($urandom_range(0, 1));
    end
    return ev;
  endfunction

  function automatic void add_row(input logic [1:0] m, input logic [31:0] now,
                                  input logic [9:0] len, input logic [15:0] id,
                                  input logic [31:0] ip, input logic [15:0] port,
                                  input logic auth, input bit fixed = 1'b0,
                                  input action_t act = ACT_NONE, input logic [2:0] slot = '0,
                                  input logic [31:0] dip = '0, input logic [15:0] dport = '0);
    script_row_t r;
    r.ev.mode = m;
    r.ev.now  = now;
    r.ev.len  = len;
    r.ev.txid = id;
    r.ev.ip   = ip;
    r.ev.port = port;
    r.ev.auth = auth;
    r.fixed   = fixed;
    r.want.action  = act;
    r.want.slot    = slot;
    r.want.dip     = dip;
    r.want.dport   = dport;
    r.want.expired = '0;
    script_q.push_back(r);
  endfunction

  task automatic send_event(input dns_event_t ev, input bit fixed, input relay_verdict_t want);
    relay_verdict_t got;
    @(negedge clk);
    in_mode             = ev.mode;
    in_now_ms           = ev.now;
    in_packet_length    = ev.len;
    in_transaction_id   = ev.txid;
    in_source_ip        = ev.ip;
    in_source_port      = ev.port;
    in_is_authenticated = ev.auth;
    start               = 1'b1;
    do @(posedge clk); while (busy);
    got = relay_decide(ev);
    verdict_q.push_back(fixed ? want : got);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    timeout_now = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin : check_result
    relay_verdict_t want;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result word: action %0d", out_action);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_action);
          fail_count++;
        end
        if (out_slot_index !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, out_slot_index);
          fail_count++;
        end
        if (out_dest_ip !== want.dip) begin
          $error("dest_ip: expected %h, got %h", want.dip, out_dest_ip);
          fail_count++;
        end
        if (out_dest_port !== want.dport) begin
          $error("dest_port: expected %h, got %h", want.dport, out_dest_port);
          fail_count++;
        end
        if (out_expired_count !== want.expired) begin
          $error("expired_count: expected %0d, got %0d", want.expired, out_expired_count);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    relay_verdict_t blank;
    dns_event_t     ev;
    logic [15:0]    phase_timeout [4];
    blank.action  = ACT_NONE;
    blank.slot    = '0;
    blank.dip     = '0;
    blank.dport   = '0;
    blank.expired = '0;
    for (int i = 0; i < SLOTS; i++) begin
      pend_valid[i] = 1'b0;
      pend_txid[i]  = '0;
      pend_ip[i]    = '0;
      pend_port[i]  = '0;
      pend_stamp[i] = '0;
    end
    phase_timeout[0] = 16'd0;
    phase_timeout[1] = 16'hFFFF;
    phase_timeout[2] = 16'($urandom_range(1, 65534));
    phase_timeout[3] = TIMEOUT_RESET;

    add_row(MODE_QUERY, 0, 11, 0, 0, 0, 0, 1, ACT_BAD_LEN);
    add_row(MODE_QUERY, 0, 12, 16'h0101, 32'h01020304, 1000, 0, 1, ACT_SPOOF);
    add_row(MODE_QUERY, 1, 496, 16'h0202, 32'h01020305, 1001, 0, 1, ACT_SPOOF);
    add_row(MODE_QUERY, 1, 497, 16'h0303, 32'h01020306, 1002, 0, 1, ACT_BAD_LEN);
    add_row(MODE_QUERY, 2, 1023, 16'h0404, 32'h01020307, 1003, 0, 1, ACT_BAD_LEN);
    add_row(MODE_QUERY, 2, 1, 16'h0505, 32'h01020308, 1004, 1, 1, ACT_BAD_LEN);
    add_row(MODE_QUERY, 3, 0, 16'h0606, 32'h01020309, 1005, 1, 1, ACT_BAD_LEN);
    add_row(MODE_REPLY, 3, 1, 0, 0, 0, 0, 1, ACT_BAD_LEN);
    add_row(MODE_REPLY, 4, 100, 16'h1234, 0, 0, 0, 1, ACT_NO_MATCH);
    add_row(MODE_TICK, 5, 0, 0, 0, 0, 0, 1, ACT_NONE);
    add_row(MODE_UNUSED, 6, 1023, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 1, 1, ACT_NONE);
    add_row(MODE_QUERY, 1000, 2, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 1, 1, ACT_FORWARD, 0);
    add_row(MODE_QUERY, 1000, 1023, 0, 0, 0, 1, 1, ACT_FORWARD, 1);
    add_row(MODE_QUERY, 1500, 512, 16'h5A5A, 32'h0A000001, 53, 1);
    add_row(MODE_QUERY, 1600, 40, 16'h5A5A, 32'h0A000002, 16'h8000, 1);
    add_row(MODE_QUERY, 1700, 40, 16'h0001, 32'h0A000003, 5353, 1);
    add_row(MODE_QUERY, 1800, 40, 16'h0002, 32'h0A000004, 5354, 1, 1, ACT_FULL);
    add_row(MODE_REPLY, 1900, 512, 16'hFFFF, 0, 0, 0, 1, ACT_DELIVERED, 0,
            32'hFFFFFFFF, 16'hFFFF);
    add_row(MODE_REPLY, 1900, 60, 16'hFFFF, 0, 0, 0);
    add_row(MODE_REPLY, 2000, 60, 16'h5A5A, 0, 0, 1);
    add_row(MODE_TICK, 4000, 0, 0, 0, 0, 0);
    add_row(MODE_TICK, 4001, 0, 0, 0, 0, 0);
    add_row(MODE_QUERY, 32'hFFFFFFF0, 80, 16'hBEEF, 32'hC0A80102, 16'h8000, 1);
    add_row(MODE_TICK, 32'h00000010, 0, 0, 0, 0, 1);
    add_row(MODE_REPLY, 32'h00001000, 80, 16'hBEEF, 0, 0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script_q[k]) send_event(script_q[k].ev, script_q[k].fixed, script_q[k].want);
    drain();
    clock_ms = 32'h00002000;

    for (int p = 0; p < 4; p++) begin
      write_timeout(phase_timeout[p]);
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        ev = make_event();
        send_event(ev, 1'b0, blank);
        if ($urandom_range(0, 99) < idle_pct[p]) begin
          @(negedge clk);
          start = 1'b0;
          repeat ($urandom_range(1, 14)) @(negedge clk);
        end
      end
      drain();
    end

    repeat (2 * SLOTS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
